@@ rtl/srms_pkg.sv @@
// Package with the shared types, constants and codes of the sliding RMS envelope follower.
package srms_pkg;

  localparam int SAMPLE_W   = 16;
  localparam int COEFF_W    = 16;
  localparam int ENV_W      = 16;
  localparam int WINDOW_MAX = 1024;
  localparam int POS_W      = $clog2(WINDOW_MAX);
  localparam int LEN_W      = POS_W + 1;
  localparam int SQ_W       = 2 * (SAMPLE_W - 1) + 1;
  localparam int SUM_W      = SQ_W + POS_W;
  localparam int MEAN_W     = SQ_W;
  localparam int RAD_W      = 2 * SAMPLE_W;
  localparam int ROOT_W     = SAMPLE_W;
  localparam int REM_W      = ROOT_W + 1;
  localparam int MUL_W      = SAMPLE_W + 2;
  localparam int PROD_W     = 2 * MUL_W;
  localparam int SCL_W      = ENV_W + 1;
  localparam int DIV_STEPS  = SUM_W;
  localparam int SQRT_STEPS = RAD_W / 2;
  localparam int CNT_W      = $clog2(DIV_STEPS);

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_ATTACK  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_RELEASE = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] CFG_WINLEN  = CFG_IDX_W'(2);

  localparam logic [LEN_W-1:0]  LEN_RESET = LEN_W'(WINDOW_MAX);
  localparam logic [SUM_W-1:0]  MEAN_MAX  = SUM_W'(1) << (2 * (SAMPLE_W - 1));

  typedef enum logic {
    ALU_SUB,
    ALU_ADD
  } alu_op_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SQUARE,
    ST_ACCUM,
    ST_DIV,
    ST_MEAN,
    ST_SQRT,
    ST_SCALE,
    ST_FOLLOW
  } state_e;

  typedef struct packed {
    alu_op_e                  op;
    logic [SUM_W-1:0]         a;
    logic [SUM_W-1:0]         b;
    logic signed [MUL_W-1:0]  ma;
    logic signed [MUL_W-1:0]  mb;
  } alu_req_t;

  typedef struct packed {
    logic [SUM_W-1:0]         res;
    logic                     borrow;
    logic signed [PROD_W-1:0] prod;
  } alu_rsp_t;

endpackage

@@ rtl/srms_sample_if.sv @@
// Valid/ready channel interface that carries one signed audio sample per transaction.
interface srms_sample_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [srms_pkg::SAMPLE_W-1:0] sample;

  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

@@ rtl/srms_env_if.sv @@
// Valid/ready channel interface that carries one envelope value per transaction.
interface srms_env_if;
  logic                          valid;
  logic                          ready;
  logic [srms_pkg::ENV_W-1:0]    envelope_out;

  modport source (output valid, output envelope_out, input ready);
  modport sink   (input valid, input envelope_out, output ready);
endinterface

@@ rtl/srms_sqmem.sv @@
// Window store of squared samples: one write port and one registered read port.
module srms_sqmem (
  input  logic                        clk_i,
  input  logic                        we_i,
  input  logic [srms_pkg::POS_W-1:0]  waddr_i,
  input  logic [srms_pkg::SQ_W-1:0]   wdata_i,
  input  logic                        re_i,
  input  logic [srms_pkg::POS_W-1:0]  raddr_i,
  output logic [srms_pkg::SQ_W-1:0]   rdata_o
);

  logic [srms_pkg::SQ_W-1:0] mem_q [srms_pkg::WINDOW_MAX];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

@@ rtl/srms_alu.sv @@
// Shared arithmetic unit: one wide add/subtract with borrow and one signed multiplier.
module srms_alu (
  input  srms_pkg::alu_req_t req_i,
  output srms_pkg::alu_rsp_t rsp_o
);

  logic [srms_pkg::SUM_W:0] wide;

  // The extra top bit is the borrow of a subtraction.
  always_comb begin
    if (req_i.op == srms_pkg::ALU_ADD) begin
      wide = {1'b0, req_i.a} + {1'b0, req_i.b};
    end else begin
      wide = {1'b0, req_i.a} - {1'b0, req_i.b};
    end
    rsp_o.res    = wide[srms_pkg::SUM_W-1:0];
    rsp_o.borrow = wide[srms_pkg::SUM_W];
    rsp_o.prod   = req_i.ma * req_i.mb;
  end

endmodule

@@ rtl/sliding_rms_envelope_follower.sv @@
// Top level of the sliding-window RMS envelope follower with its sequencer and datapath.
//
//   channel  | direction | payload                  | handshake
//   ---------+-----------+--------------------------+------------------------------
//   in_i     | sink      | sample, signed Q1.15     | valid & ready
//   out_o    | source    | envelope_out, Q1.15      | valid & ready
//   cfg      | write     | cfg_idx_i, cfg_data_i    | cfg_we_i
//
// An item passes through the sequencer in order: the square and accumulate steps update the
// window, the restoring divide by the window length runs one quotient bit at a time on the
// shared subtractor, a mean step loads the root, the digit-by-digit square root runs on the
// same subtractor, and the scale and follow steps run the follower on the shared multiplier
// and adder. The input is ready only while the sequencer is idle, so a new transaction is
// accepted only once the sequencer has finished the previous one.
// Reset needs no clearing pass: a wrap flag marks whether the window has filled once, and
// a square read before that reads as zero. A result waits in the output register while the
// next transaction is accepted; the sequencer holds in its last step only if the previous
// result has still not been taken.
module sliding_rms_envelope_follower (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  srms_sample_if.sink                       in_i,
  srms_env_if.source                        out_o,
  input  logic                              cfg_we_i,
  input  logic [srms_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [srms_pkg::CFG_DATA_W-1:0]   cfg_data_i
);

  srms_pkg::state_e state_q, state_d;

  // Configuration registers. The window length is kept already clamped to 1..WINDOW_MAX.
  logic [srms_pkg::COEFF_W-1:0] attack_q;
  logic [srms_pkg::COEFF_W-1:0] release_q;
  logic [srms_pkg::LEN_W-1:0]   len_q;
  logic [srms_pkg::LEN_W-1:0]   len_wr;

  // Window state.
  logic [srms_pkg::SUM_W-1:0]   sum_q;
  logic [srms_pkg::POS_W-1:0]   pos_q;
  logic                         wrapped_q;
  logic [srms_pkg::LEN_W-1:0]   pos_inc;

  // Working registers of the sequencer.
  logic [srms_pkg::SAMPLE_W-1:0]    mag_q;
  logic [srms_pkg::SAMPLE_W-1:0]    mag;
  logic [srms_pkg::SQ_W-1:0]        sq_q;
  logic [srms_pkg::SUM_W-1:0]       dq_q;
  logic [srms_pkg::REM_W-1:0]       rem_q;
  logic [srms_pkg::RAD_W-1:0]       rad_q;
  logic [srms_pkg::ROOT_W-1:0]      root_q;
  logic signed [srms_pkg::SCL_W-1:0] scl_q;
  logic [srms_pkg::CNT_W-1:0]       cnt_q;

  logic [srms_pkg::ENV_W-1:0]   env_q;
  logic                         out_valid_q;

  logic                         in_fire;
  logic                         out_free;
  logic                         env_load;
  logic [srms_pkg::SQ_W-1:0]    rd_data;
  logic [srms_pkg::SQ_W-1:0]    old_sq;
  logic [srms_pkg::REM_W+1:0]   rem_shift;
  logic [srms_pkg::LEN_W:0]     div_trial;
  logic signed [srms_pkg::SCL_W-1:0] env_diff;
  logic [srms_pkg::COEFF_W-1:0] coeff;
  logic [srms_pkg::MEAN_W-1:0]  mean;

  srms_pkg::alu_req_t alu_req;
  srms_pkg::alu_rsp_t alu_rsp;

  assign in_fire  = in_i.valid && in_i.ready;
  assign out_free = !out_valid_q || out_o.ready;
  assign env_load = (state_q == srms_pkg::ST_FOLLOW) && out_free;

  assign out_o.valid        = out_valid_q;
  assign out_o.envelope_out = env_q;

  // Magnitude of the sample. The most negative sample gives 2^15, which still fits.
  assign mag = in_i.sample[srms_pkg::SAMPLE_W-1] ? srms_pkg::SAMPLE_W'(-in_i.sample)
                                                 : srms_pkg::SAMPLE_W'(in_i.sample);

  // Until the window has wrapped once, the entry about to be overwritten was never
  // written since the last clear, so it counts as zero.
  assign old_sq = wrapped_q ? rd_data : '0;

  assign pos_inc = {1'b0, pos_q} + srms_pkg::LEN_W'(1);

  // Operands of one divide step and one root step.
  assign div_trial = {rem_q[srms_pkg::LEN_W-1:0], dq_q[srms_pkg::SUM_W-1]};
  assign rem_shift = {rem_q, rad_q[srms_pkg::RAD_W-1 -: 2]};

  // The envelope minus the RMS value; negative means the RMS value rises above it.
  assign env_diff = srms_pkg::SCL_W'({1'b0, env_q}) - srms_pkg::SCL_W'({1'b0, root_q});
  assign coeff    = env_diff[srms_pkg::SCL_W-1] ? attack_q : release_q;

  // The quotient cannot pass full scale while the window is cleared on each length
  // change, but it is clamped all the same.
  assign mean = (dq_q > srms_pkg::MEAN_MAX) ? srms_pkg::MEAN_MAX[srms_pkg::MEAN_W-1:0]
                                            : dq_q[srms_pkg::MEAN_W-1:0];

  // Window length from the low LEN_W bits as written, with zero taken as one and larger values saturated.
  always_comb begin
    len_wr = cfg_data_i[srms_pkg::LEN_W-1:0];
    if (len_wr == '0) begin
      len_wr = srms_pkg::LEN_W'(1);
    end else if (len_wr > srms_pkg::LEN_RESET) begin
      len_wr = srms_pkg::LEN_RESET;
    end
  end

  srms_sqmem u_sqmem (
    .clk_i   (clk_i),
    .we_i    (state_q == srms_pkg::ST_ACCUM),
    .waddr_i (pos_q),
    .wdata_i (sq_q),
    .re_i    (in_fire),
    .raddr_i (pos_q),
    .rdata_o (rd_data)
  );

  srms_alu u_alu (
    .req_i (alu_req),
    .rsp_o (alu_rsp)
  );

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      srms_pkg::ST_IDLE:   if (in_fire) state_d = srms_pkg::ST_SQUARE;
      srms_pkg::ST_SQUARE: state_d = srms_pkg::ST_ACCUM;
      srms_pkg::ST_ACCUM:  state_d = srms_pkg::ST_DIV;
      srms_pkg::ST_DIV:    if (cnt_q == '0) state_d = srms_pkg::ST_MEAN;
      srms_pkg::ST_MEAN:   state_d = srms_pkg::ST_SQRT;
      srms_pkg::ST_SQRT:   if (cnt_q == '0) state_d = srms_pkg::ST_SCALE;
      srms_pkg::ST_SCALE:  state_d = srms_pkg::ST_FOLLOW;
      srms_pkg::ST_FOLLOW: if (out_free) state_d = srms_pkg::ST_IDLE;
      default:             state_d = srms_pkg::ST_IDLE;
    endcase
  end

  // Outputs of the sequencer: input ready and the operands of the shared unit.
  always_comb begin
    in_i.ready = 1'b0;
    alu_req    = '0;
    alu_req.op = srms_pkg::ALU_SUB;
    case (state_q)
      srms_pkg::ST_IDLE: begin
        in_i.ready = 1'b1;
      end
      srms_pkg::ST_SQUARE: begin
        // Square the magnitude and take out the square being overwritten.
        alu_req.ma = srms_pkg::MUL_W'(mag_q);
        alu_req.mb = srms_pkg::MUL_W'(mag_q);
        alu_req.a  = sum_q;
        alu_req.b  = srms_pkg::SUM_W'(old_sq);
      end
      srms_pkg::ST_ACCUM: begin
        alu_req.op = srms_pkg::ALU_ADD;
        alu_req.a  = dq_q;
        alu_req.b  = srms_pkg::SUM_W'(sq_q);
      end
      srms_pkg::ST_DIV: begin
        alu_req.a = srms_pkg::SUM_W'(div_trial);
        alu_req.b = srms_pkg::SUM_W'(len_q);
      end
      srms_pkg::ST_SQRT: begin
        alu_req.a = srms_pkg::SUM_W'(rem_shift);
        alu_req.b = srms_pkg::SUM_W'({root_q, 2'b01});
      end
      srms_pkg::ST_SCALE: begin
        // coeff * env + (1 - coeff) * rms equals rms + coeff * (env - rms).
        alu_req.ma = srms_pkg::MUL_W'({1'b0, coeff});
        alu_req.mb = srms_pkg::MUL_W'(env_diff);
      end
      srms_pkg::ST_FOLLOW: begin
        alu_req.op = srms_pkg::ALU_ADD;
        alu_req.a  = srms_pkg::SUM_W'(root_q);
        alu_req.b  = srms_pkg::SUM_W'(scl_q);
      end
      default: begin
        alu_req.op = srms_pkg::ALU_SUB;
      end
    endcase
  end

  // Control and architectural state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= srms_pkg::ST_IDLE;
      cnt_q       <= '0;
      attack_q    <= '0;
      release_q   <= '0;
      len_q       <= srms_pkg::LEN_RESET;
      sum_q       <= '0;
      pos_q       <= '0;
      wrapped_q   <= 1'b0;
      env_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= (out_valid_q && !out_o.ready) || env_load;

      case (state_q)
        srms_pkg::ST_ACCUM: begin
          sum_q <= alu_rsp.res;
          cnt_q <= srms_pkg::CNT_W'(srms_pkg::DIV_STEPS - 1);
          if (pos_inc >= len_q) begin
            pos_q     <= '0;
            wrapped_q <= 1'b1;
          end else begin
            pos_q <= pos_inc[srms_pkg::POS_W-1:0];
          end
        end
        srms_pkg::ST_DIV:  cnt_q <= cnt_q - srms_pkg::CNT_W'(1);
        srms_pkg::ST_MEAN: cnt_q <= srms_pkg::CNT_W'(srms_pkg::SQRT_STEPS - 1);
        srms_pkg::ST_SQRT: cnt_q <= cnt_q - srms_pkg::CNT_W'(1);
        default: begin
          cnt_q <= cnt_q;
        end
      endcase

      if (env_load) begin
        env_q <= alu_rsp.res[srms_pkg::ENV_W-1:0];
      end

      // The user is to write only while the sequencer is idle; the block itself does not enforce
      // it. A new window length restarts the window empty; the envelope is kept.
      if (cfg_we_i) begin
        case (cfg_idx_i)
          srms_pkg::CFG_ATTACK:  attack_q  <= cfg_data_i[srms_pkg::COEFF_W-1:0];
          srms_pkg::CFG_RELEASE: release_q <= cfg_data_i[srms_pkg::COEFF_W-1:0];
          srms_pkg::CFG_WINLEN: begin
            len_q     <= len_wr;
            sum_q     <= '0;
            pos_q     <= '0;
            wrapped_q <= 1'b0;
          end
          default: begin
            len_q <= len_q;
          end
        endcase
      end
    end
  end

  // Working registers of the square, divide, root and follower steps.
  always_ff @(posedge clk_i) begin
    case (state_q)
      srms_pkg::ST_IDLE: begin
        if (in_fire) begin
          mag_q <= mag;
        end
      end
      srms_pkg::ST_SQUARE: begin
        sq_q <= alu_rsp.prod[srms_pkg::SQ_W-1:0];
        dq_q <= alu_rsp.res;
      end
      srms_pkg::ST_ACCUM: begin
        // The new sum becomes the dividend; quotient bits shift in from the bottom.
        dq_q  <= alu_rsp.res;
        rem_q <= '0;
      end
      srms_pkg::ST_DIV: begin
        if (alu_rsp.borrow) begin
          rem_q <= srms_pkg::REM_W'(div_trial[srms_pkg::LEN_W-1:0]);
        end else begin
          rem_q <= srms_pkg::REM_W'(alu_rsp.res[srms_pkg::LEN_W-1:0]);
        end
        dq_q <= {dq_q[srms_pkg::SUM_W-2:0], !alu_rsp.borrow};
      end
      srms_pkg::ST_MEAN: begin
        rad_q  <= srms_pkg::RAD_W'(mean);
        rem_q  <= '0;
        root_q <= '0;
      end
      srms_pkg::ST_SQRT: begin
        // Two radicand bits a step; the root gains one bit a step.
        if (alu_rsp.borrow) begin
          rem_q <= rem_shift[srms_pkg::REM_W-1:0];
        end else begin
          rem_q <= alu_rsp.res[srms_pkg::REM_W-1:0];
        end
        root_q <= {root_q[srms_pkg::ROOT_W-2:0], !alu_rsp.borrow};
        rad_q  <= {rad_q[srms_pkg::RAD_W-3:0], 2'b00};
      end
      srms_pkg::ST_SCALE: begin
        // Arithmetic shift by 16 of the product, which floors it.
        scl_q <= alu_rsp.prod[srms_pkg::SCL_W+15:16];
      end
      default: begin
        mag_q <= mag_q;
      end
    endcase
  end

endmodule
